>>> hdl/hdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hdu_pkg;

	// Request kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SEND = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_BIT_TICKS     = 2'd0;
	localparam logic [1:0] CFG_RX_FIRST_WAIT = 2'd1;
	localparam logic [1:0] CFG_TX_FIRST_WAIT = 2'd2;

	localparam logic [7:0] BIT_TICKS_RST     = 8'd54;
	localparam logic [7:0] RX_FIRST_WAIT_RST = 8'd71;
	localparam logic [7:0] TX_FIRST_WAIT_RST = 8'd46;

	// Bit sequencing: eight data bits, then the stop bits up to the last step
	localparam logic [3:0] DATA_BITS    = 4'd8;
	localparam logic [3:0] TX_LAST_STOP = 4'd10;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_RX,
		MODE_TX
	} mode_t;

	typedef struct packed {
		logic       we;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic       push;
		logic [7:0] data;
	} ring_push_t;

	typedef struct packed {
		logic popped;
		logic has_data;
	} ring_stat_t;

	typedef struct packed {
		logic tx_line;
		logic bus_drive;
		logic busy;
		logic frame_error;
	} ctrl_stat_t;

	typedef struct packed {
		logic       tx_line;
		logic       bus_drive;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       has_data;
		logic       busy_res;
		logic       frame_error;
	} res_t;

endpackage

`default_nettype wire

>>> hdl/hdu_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface hdu_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface hdu_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic       rx_line;
	logic [7:0] tx_byte;

	modport source (output valid, output kind, output rx_line, output tx_byte, input ready);
	modport sink (input valid, input kind, input rx_line, input tx_byte, output ready);
endinterface

interface hdu_res_if;
	logic       valid;
	logic       ready;
	logic       tx_line;
	logic       bus_drive;
	logic [7:0] rx_byte;
	logic       rx_valid;
	logic       has_data;
	logic       busy_res;
	logic       frame_error;

	modport source (
		output valid, output tx_line, output bus_drive, output rx_byte, output rx_valid,
		output has_data, output busy_res, output frame_error, input ready
	);
	modport sink (
		input valid, input tx_line, input bus_drive, input rx_byte, input rx_valid,
		input has_data, input busy_res, input frame_error, output ready
	);
endinterface

`default_nettype wire

>>> hdl/hdu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hdu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  hdu_pkg::cfg_wr_t   cfg_wr,
	input  logic               go,
	input  logic [1:0]         kind,
	input  logic               rx_line,
	input  logic [7:0]         tx_byte,
	output hdu_pkg::ring_push_t push,
	output hdu_pkg::ctrl_stat_t stat
);
	import hdu_pkg::*;

	logic [7:0] bit_ticks_q;
	logic [7:0] rx_first_wait_q;
	logic [7:0] tx_first_wait_q;

	mode_t      mode_q, mode_d;
	logic [3:0] step_q, step_d;
	logic [7:0] tc_q, tc_d;
	logic [7:0] rx_shift_q, rx_shift_d;
	logic [7:0] tx_shift_q, tx_shift_d;
	logic       err_q, err_d;
	logic       line_q, line_d;
	logic       armed_q, armed_d;

	logic       wait_done;
	logic [7:0] tc_next;
	logic       rx_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q     <= BIT_TICKS_RST;
			rx_first_wait_q <= RX_FIRST_WAIT_RST;
			tx_first_wait_q <= TX_FIRST_WAIT_RST;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				CFG_BIT_TICKS:     bit_ticks_q     <= cfg_wr.data;
				CFG_RX_FIRST_WAIT: rx_first_wait_q <= cfg_wr.data;
				CFG_TX_FIRST_WAIT: tx_first_wait_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// A wait of zero behaves as one: the next tick ends it.
	assign wait_done = (tc_q <= 8'd1);
	assign tc_next   = wait_done ? bit_ticks_q : tc_q - 8'd1;
	assign rx_done   = go && (kind == KIND_TICK) && (mode_q == MODE_RX) && wait_done
		&& (step_q >= DATA_BITS);

	// Next state
	always_comb begin
		mode_d     = mode_q;
		step_d     = step_q;
		tc_d       = tc_q;
		rx_shift_d = rx_shift_q;
		tx_shift_d = tx_shift_q;
		err_d      = err_q;
		line_d     = line_q;
		armed_d    = armed_q;
		if (go) begin
			case (kind)
				KIND_TICK: begin
					case (mode_q)
						MODE_RX: begin
							tc_d = tc_next;
							if (wait_done) begin
								if (step_q < DATA_BITS) begin
									rx_shift_d = {rx_line, rx_shift_q[7:1]};
									step_d     = step_q + 4'd1;
								end else begin
									if (!rx_line) begin
										err_d = 1'b1;
									end
									armed_d = 1'b1;
									mode_d  = MODE_IDLE;
									step_d  = 4'd0;
								end
							end
						end
						MODE_TX: begin
							tc_d = tc_next;
							if (wait_done) begin
								if (step_q < DATA_BITS) begin
									line_d     = tx_shift_q[0];
									tx_shift_d = {1'b0, tx_shift_q[7:1]};
									step_d     = step_q + 4'd1;
								end else if (step_q < TX_LAST_STOP) begin
									line_d = 1'b1;
									step_d = step_q + 4'd1;
								end else begin
									line_d  = 1'b1;
									mode_d  = MODE_IDLE;
									step_d  = 4'd0;
									armed_d = 1'b1;
								end
							end
						end
						default: begin
							// The receive line is ignored while transmitting.
							if (armed_q && !rx_line) begin
								mode_d     = MODE_RX;
								step_d     = 4'd0;
								tc_d       = rx_first_wait_q;
								rx_shift_d = 8'd0;
								armed_d    = 1'b0;
							end
						end
					endcase
				end
				KIND_SEND: begin
					// A send drops any receive in progress and restarts the frame.
					mode_d     = MODE_TX;
					tx_shift_d = tx_byte;
					line_d     = 1'b0;
					step_d     = 4'd0;
					tc_d       = tx_first_wait_q;
					armed_d    = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Outputs
	always_comb begin
		push.push        = rx_done;
		push.data        = rx_shift_q;
		stat.tx_line     = line_d;
		stat.bus_drive   = (mode_d == MODE_TX);
		stat.busy        = (mode_d != MODE_IDLE);
		stat.frame_error = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			step_q     <= 4'd0;
			tc_q       <= 8'd0;
			rx_shift_q <= 8'd0;
			tx_shift_q <= 8'd0;
			err_q      <= 1'b0;
			line_q     <= 1'b1;
			armed_q    <= 1'b1;
		end else begin
			mode_q     <= mode_d;
			step_q     <= step_d;
			tc_q       <= tc_d;
			rx_shift_q <= rx_shift_d;
			tx_shift_q <= tx_shift_d;
			err_q      <= err_d;
			line_q     <= line_d;
			armed_q    <= armed_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/hdu_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module hdu_ring #(
	parameter int RING_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hdu_pkg::ring_push_t push,
	input  logic                pop_req,
	output hdu_pkg::ring_stat_t stat,
	output logic [7:0]          rd_data
);
	import hdu_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic [7:0]       mem [RING_DEPTH];
	logic [PTR_W-1:0] wptr_q, wptr_d;
	logic [PTR_W-1:0] rptr_q, rptr_d;
	logic             got_q, got_d;
	logic             nonempty;
	logic             pop;
	logic [7:0]       rd_q;

	// got_q keeps the ring non-empty when a full wrap brings the pointers together.
	assign nonempty = got_q || (rptr_q != wptr_q);
	assign pop      = pop_req && nonempty;

	always_comb begin
		wptr_d = wptr_q;
		rptr_d = rptr_q;
		got_d  = got_q;
		if (push.push) begin
			wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			got_d  = 1'b1;
		end else if (pop) begin
			rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			got_d  = 1'b0;
		end
	end

	assign stat.popped   = pop;
	assign stat.has_data = got_d || (rptr_d != wptr_d);
	assign rd_data       = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			got_q  <= 1'b0;
		end else begin
			wptr_q <= wptr_d;
			rptr_q <= rptr_d;
			got_q  <= got_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem[wptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q <= mem[rptr_q];
		end
	end

endmodule

`default_nettype wire

>>> hdl/hdu_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module hdu_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  hdu_pkg::res_t in_res,
	input  logic          out_ready,
	output logic          out_valid,
	output hdu_pkg::res_t out_res,
	output logic          room
);
	import hdu_pkg::*;

	res_t       out_q, out_d;
	res_t       skid_q, skid_d;
	logic       out_v_q, out_v_d;
	logic       skid_v_q, skid_v_d;
	logic       take;
	logic [1:0] occ;

	assign take = out_v_q && out_ready;
	assign occ  = {1'b0, out_v_q} + {1'b0, skid_v_q} + {1'b0, in_valid};
	// A new request is taken only if the result it makes next cycle is sure of a slot.
	assign room = (occ < 2'd2) || ((occ == 2'd2) && take);

	always_comb begin
		out_d    = out_q;
		out_v_d  = out_v_q;
		skid_d   = skid_q;
		skid_v_d = skid_v_q;
		if (take || !out_v_q) begin
			if (skid_v_q) begin
				out_d    = skid_q;
				out_v_d  = 1'b1;
				skid_d   = in_res;
				skid_v_d = in_valid;
			end else begin
				out_d    = in_res;
				out_v_d  = in_valid;
				skid_v_d = 1'b0;
			end
		end else if (in_valid) begin
			skid_d   = in_res;
			skid_v_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q  <= out_v_d;
			skid_v_q <= skid_v_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q  <= out_d;
		skid_q <= skid_d;
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

>>> hdl/half_duplex_uart.sv
// Half-duplex 8N1 UART whose bit timing is counted in timer ticks.
// Requests arrive on req: a tick carries the sampled receive line, a send
// carries a byte to transmit, a read pops the oldest received byte from a
// ring of RING_DEPTH entries. Every request gives exactly one result on res,
// reporting the line level, bus direction, popped byte and the status flags
// as they stand after that request.
// Configuration writes on cfg (bit_ticks, rx_first_wait, tx_first_wait) are
// always taken and must only be issued while no result is outstanding.
// A request can be taken every clock while the output side has room. The
// accepting edge updates the control state, reads the ring and loads the
// stage register; the next edge loads the output register, or the skid
// register while a result waits there, and res offers the result from the
// output register. Throughput is one request per cycle while res.ready takes results.
// The output side has a result register and a skid register, so one more
// request is accepted while a result waits; with both full, req.ready stays
// low until res.ready takes a result.
// After reset the line is idle high, start detection is armed, the ring is
// empty, the frame error flag is clear and the bit timing registers hold
// 54, 71 and 46 ticks. The ring storage itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module half_duplex_uart #(
	parameter int RING_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	hdu_cfg_if.sink  cfg,
	hdu_req_if.sink  req,
	hdu_res_if.source res
);
	import hdu_pkg::*;

	typedef struct packed {
		ctrl_stat_t ctrl;
		ring_stat_t ring;
	} s1_t;

	cfg_wr_t    cfg_wr;
	logic       go;
	ring_push_t push;
	ctrl_stat_t ctrl_stat;
	ring_stat_t ring_stat;
	logic [7:0] rd_data;
	logic       valid_s1;
	s1_t        item_s1;
	res_t       s1_res;
	res_t       out_res;
	logic       room;

	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid && cfg.ready;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	assign req.ready = room;
	assign go        = req.valid && req.ready;

	hdu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.go      (go),
		.kind    (req.kind),
		.rx_line (req.rx_line),
		.tx_byte (req.tx_byte),
		.push    (push),
		.stat    (ctrl_stat)
	);

	hdu_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop_req (go && (req.kind == KIND_READ)),
		.stat    (ring_stat),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			item_s1 <= '{ctrl: ctrl_stat, ring: ring_stat};
		end
	end

	// The ring read data lands in the same cycle as the rest of the stage.
	always_comb begin
		s1_res.tx_line     = item_s1.ctrl.tx_line;
		s1_res.bus_drive   = item_s1.ctrl.bus_drive;
		s1_res.rx_byte     = item_s1.ring.popped ? rd_data : 8'd0;
		s1_res.rx_valid    = item_s1.ring.popped;
		s1_res.has_data    = item_s1.ring.has_data;
		s1_res.busy_res    = item_s1.ctrl.busy;
		s1_res.frame_error = item_s1.ctrl.frame_error;
	end

	hdu_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_res    (s1_res),
		.out_ready (res.ready),
		.out_valid (res.valid),
		.out_res   (out_res),
		.room      (room)
	);

	assign res.tx_line     = out_res.tx_line;
	assign res.bus_drive   = out_res.bus_drive;
	assign res.rx_byte     = out_res.rx_byte;
	assign res.rx_valid    = out_res.rx_valid;
	assign res.has_data    = out_res.has_data;
	assign res.busy_res    = out_res.busy_res;
	assign res.frame_error = out_res.frame_error;

	a_send_drives_low: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (req.kind == KIND_SEND)) |=>
			(valid_s1 && item_s1.ctrl.bus_drive && !item_s1.ctrl.tx_line))
		else $error("send request did not start a transmit frame");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> req.ready)
		else $error("request refused with no result waiting");

	a_drive_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.ctrl.bus_drive) |-> item_s1.ctrl.busy)
		else $error("bus driven while not busy");

endmodule

`default_nettype wire
